// ===== rtl/core/rv32im_alu_unit_defines.svh =====
// Assertion macros shared by the checker of the rv32im ALU unit.
// Depends on nothing; the using module must have clk and rst_n in scope.
`ifndef RV32IM_ALU_UNIT_DEFINES_SVH
`define RV32IM_ALU_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define RV_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rv32ia_pkg.sv =====
// Shared types and operation codes for the rv32im ALU unit.
// Depends on nothing; used by every module of the block.
package rv32ia_pkg;

  localparam int XLEN = 32;
  localparam int DIV_STEPS = XLEN;

  localparam logic [4:0] OP_AND   = 5'd0;
  localparam logic [4:0] OP_OR    = 5'd1;
  localparam logic [4:0] OP_ADD   = 5'd2;
  localparam logic [4:0] OP_XOR   = 5'd3;
  localparam logic [4:0] OP_SLT   = 5'd4;
  localparam logic [4:0] OP_SLTU  = 5'd5;
  localparam logic [4:0] OP_SUB   = 5'd6;
  localparam logic [4:0] OP_MUL   = 5'd8;
  localparam logic [4:0] OP_MULH  = 5'd9;
  localparam logic [4:0] OP_MULHU = 5'd11;
  localparam logic [4:0] OP_SLL   = 5'd13;
  localparam logic [4:0] OP_SRL   = 5'd14;
  localparam logic [4:0] OP_SRA   = 5'd15;
  localparam logic [4:0] OP_DIV   = 5'd24;
  localparam logic [4:0] OP_DIVU  = 5'd25;
  localparam logic [4:0] OP_REM   = 5'd26;
  localparam logic [4:0] OP_REMU  = 5'd27;

  typedef struct packed {
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [4:0]  req_type;
  } in_t;

  typedef struct packed {
    logic [31:0] result;
    logic        zero_flag;
    logic        invalid_op;
  } out_t;

  // Everything registered by the first stage.
  typedef struct packed {
    logic [4:0]  req_type;
    logic        bad;
    logic        cmp;
    logic [31:0] simple;
    logic [31:0] pp_ll;
    logic [31:0] pp_lh;
    logic [31:0] pp_hl;
    logic [31:0] pp_hh;
    logic [31:0] corr;
    logic [31:0] dividend;
    logic [31:0] divisor;
    logic        neg_q;
    logic        neg_r;
  } prep_t;

  // Side data that rides unchanged along the divider stages.
  typedef struct packed {
    logic [4:0]  req_type;
    logic        bad;
    logic        cmp;
    logic [31:0] simple;
    logic [63:0] prod;
    logic [31:0] corr;
    logic [31:0] divisor;
    logic        neg_q;
    logic        neg_r;
  } car_t;

  // Partial remainder and the dividend/quotient shift word.
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] dq;
  } div_st_t;

endpackage

// ===== rtl/core/rv32ia_prep.sv =====
// First pipeline stage: decode, simple ALU ops, multiplier partial
// products and divider operand preparation. Depends on rv32ia_pkg.
module rv32ia_prep (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              i_valid,
  input  rv32ia_pkg::in_t   i_data,
  output logic              o_valid,
  output rv32ia_pkg::prep_t o_data
);

  logic               valid_r;
  rv32ia_pkg::prep_t  data_r;
  rv32ia_pkg::prep_t  data_nxt;

  logic [31:0] a;
  logic [31:0] b;
  logic [4:0]  sh;
  logic        sgn;
  logic        na;
  logic        nb;
  logic        bz;

  always_comb begin
    a   = i_data.operand_a;
    b   = i_data.operand_b;
    sh  = b[4:0];
    sgn = (i_data.req_type == rv32ia_pkg::OP_DIV) || (i_data.req_type == rv32ia_pkg::OP_REM);
    na  = sgn & a[31];
    nb  = sgn & b[31];
    bz  = (b == 32'd0);

    data_nxt          = '0;
    data_nxt.req_type = i_data.req_type;
    data_nxt.bad      = 1'b0;
    data_nxt.cmp      = 1'b0;
    unique case (i_data.req_type)
      rv32ia_pkg::OP_AND:   data_nxt.simple = a & b;
      rv32ia_pkg::OP_OR:    data_nxt.simple = a | b;
      rv32ia_pkg::OP_ADD:   data_nxt.simple = a + b;
      rv32ia_pkg::OP_XOR:   data_nxt.simple = a ^ b;
      rv32ia_pkg::OP_SLT: begin
        data_nxt.simple = {31'd0, ($signed(a) < $signed(b))};
        data_nxt.cmp    = 1'b1;
      end
      rv32ia_pkg::OP_SLTU: begin
        data_nxt.simple = {31'd0, (a < b)};
        data_nxt.cmp    = 1'b1;
      end
      rv32ia_pkg::OP_SUB:   data_nxt.simple = a - b;
      rv32ia_pkg::OP_SLL:   data_nxt.simple = a << sh;
      rv32ia_pkg::OP_SRL:   data_nxt.simple = a >> sh;
      rv32ia_pkg::OP_SRA:   data_nxt.simple = 32'($signed(a) >>> sh);
      rv32ia_pkg::OP_MUL, rv32ia_pkg::OP_MULH, rv32ia_pkg::OP_MULHU,
      rv32ia_pkg::OP_DIV, rv32ia_pkg::OP_DIVU, rv32ia_pkg::OP_REM,
      rv32ia_pkg::OP_REMU:  data_nxt.simple = 32'd0;
      default: begin
        data_nxt.simple = 32'd0;
        data_nxt.bad    = 1'b1;
      end
    endcase

    // Unsigned 32x32 product as four 16x16 partial products.
    data_nxt.pp_ll = a[15:0]  * b[15:0];
    data_nxt.pp_lh = a[15:0]  * b[31:16];
    data_nxt.pp_hl = a[31:16] * b[15:0];
    data_nxt.pp_hh = a[31:16] * b[31:16];
    // Signed high word is the unsigned one less these sign corrections.
    data_nxt.corr  = (a[31] ? b : 32'd0) + (b[31] ? a : 32'd0);

    data_nxt.dividend = na ? (32'd0 - a) : a;
    data_nxt.divisor  = nb ? (32'd0 - b) : b;
    // A zero divisor yields all ones from the array, which must not be negated.
    data_nxt.neg_q    = (i_data.req_type == rv32ia_pkg::OP_DIV) & (na ^ nb) & ~bz;
    data_nxt.neg_r    = (i_data.req_type == rv32ia_pkg::OP_REM) & na;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_data  = data_r;

endmodule

// ===== rtl/core/rv32ia_div_step.sv =====
// One restoring-division stage: one quotient bit per stage, side data
// carried along unchanged. Depends on rv32ia_pkg.
module rv32ia_div_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                i_valid,
  input  rv32ia_pkg::car_t    i_car,
  input  rv32ia_pkg::div_st_t i_st,
  output logic                o_valid,
  output rv32ia_pkg::car_t    o_car,
  output rv32ia_pkg::div_st_t o_st
);

  logic                valid_r;
  rv32ia_pkg::car_t    car_r;
  rv32ia_pkg::div_st_t st_r;
  rv32ia_pkg::div_st_t st_nxt;

  logic [32:0] trial;
  logic [33:0] diff;
  logic        ge;

  always_comb begin
    trial  = {i_st.rem, i_st.dq[31]};
    diff   = {1'b0, trial} - {2'b00, i_car.divisor};
    ge     = ~diff[33];
    st_nxt.rem = ge ? diff[31:0] : trial[31:0];
    st_nxt.dq  = {i_st.dq[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      car_r <= i_car;
      st_r  <= st_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_car   = car_r;
  assign o_st    = st_r;

endmodule

// ===== rtl/core/rv32ia_finish.sv =====
// Last stage: sign fix-up of quotient, remainder and high product, result
// selection and flags, into the output register. Depends on rv32ia_pkg.
module rv32ia_finish (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                i_valid,
  input  rv32ia_pkg::car_t    i_car,
  input  rv32ia_pkg::div_st_t i_st,
  output logic                o_valid,
  output rv32ia_pkg::out_t    o_data
);

  logic              valid_r;
  rv32ia_pkg::out_t  data_r;
  rv32ia_pkg::out_t  data_nxt;
  logic [31:0]       res;

  always_comb begin
    unique case (i_car.req_type)
      rv32ia_pkg::OP_MUL:   res = i_car.prod[31:0];
      rv32ia_pkg::OP_MULH:  res = i_car.prod[63:32] - i_car.corr;
      rv32ia_pkg::OP_MULHU: res = i_car.prod[63:32];
      rv32ia_pkg::OP_DIV, rv32ia_pkg::OP_DIVU:
        res = i_car.neg_q ? (32'd0 - i_st.dq) : i_st.dq;
      rv32ia_pkg::OP_REM, rv32ia_pkg::OP_REMU:
        res = i_car.neg_r ? (32'd0 - i_st.rem) : i_st.rem;
      default:              res = i_car.simple;
    endcase

    data_nxt.result     = i_car.bad ? 32'd0 : res;
    data_nxt.invalid_op = i_car.bad;
    if (i_car.bad) begin
      data_nxt.zero_flag = 1'b0;
    end else if (i_car.cmp) begin
      data_nxt.zero_flag = res[0];
    end else begin
      data_nxt.zero_flag = (res == 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_data  = data_r;

endmodule

// ===== rtl/core/rv32im_alu_unit.sv =====
// Top level of the rv32im ALU unit: prep stage, divider array, finish stage.
// Depends on rv32ia_pkg, rv32ia_prep, rv32ia_div_step and rv32ia_finish.

// Every operation passes the same stages from acceptance to result: one
// stage for decode, simple ops and partial products, 32 stages of the
// divider array that yields one quotient bit per stage, and the output
// stage. A new transaction is taken every cycle unless stalled; the whole
// pipeline advances together and holds while the output register is full
// and not taken, so in_ready follows out_ready whenever a result is waiting.
module rv32im_alu_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rv32ia_pkg::in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rv32ia_pkg::out_t out_data
);

  logic                en;
  logic                prep_valid;
  rv32ia_pkg::prep_t   prep_data;

  logic                v   [0:rv32ia_pkg::DIV_STEPS];
  rv32ia_pkg::car_t    car [0:rv32ia_pkg::DIV_STEPS];
  rv32ia_pkg::div_st_t st  [0:rv32ia_pkg::DIV_STEPS];

  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  rv32ia_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .i_valid (in_valid),
    .i_data  (in_data),
    .o_valid (prep_valid),
    .o_data  (prep_data)
  );

  // The product is summed alongside the first divider step.
  always_comb begin
    v[0]            = prep_valid;
    car[0].req_type = prep_data.req_type;
    car[0].bad      = prep_data.bad;
    car[0].cmp      = prep_data.cmp;
    car[0].simple   = prep_data.simple;
    car[0].prod     = {prep_data.pp_hh, prep_data.pp_ll}
                    + {16'd0, prep_data.pp_lh, 16'd0}
                    + {16'd0, prep_data.pp_hl, 16'd0};
    car[0].corr     = prep_data.corr;
    car[0].divisor  = prep_data.divisor;
    car[0].neg_q    = prep_data.neg_q;
    car[0].neg_r    = prep_data.neg_r;
    st[0].rem       = 32'd0;
    st[0].dq        = prep_data.dividend;
  end

  for (genvar k = 0; k < rv32ia_pkg::DIV_STEPS; k++) begin : g_div
    rv32ia_div_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .i_valid (v[k]),
      .i_car   (car[k]),
      .i_st    (st[k]),
      .o_valid (v[k+1]),
      .o_car   (car[k+1]),
      .o_st    (st[k+1])
    );
  end

  rv32ia_finish u_finish (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .i_valid (v[rv32ia_pkg::DIV_STEPS]),
    .i_car   (car[rv32ia_pkg::DIV_STEPS]),
    .i_st    (st[rv32ia_pkg::DIV_STEPS]),
    .o_valid (out_valid),
    .o_data  (out_data)
  );

endmodule

// ===== rtl/core/rv32ia_checker.sv =====
// Port-level checker for the rv32im ALU unit, bound to the top level.
// Depends on rv32ia_pkg and rv32im_alu_unit_defines.svh.
`include "rv32im_alu_unit_defines.svh"

module rv32ia_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input rv32ia_pkg::in_t  in_data,
  input logic             out_valid,
  input logic             out_ready,
  input rv32ia_pkg::out_t out_data
);

  // A result that is not taken must hold.
  `RV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // The pipeline only stalls when a result is waiting.
  `RV_ASSERT_IMPL(a_ready_rule, 1'b1, in_ready == (!out_valid || out_ready), "in_ready does not follow the output stage")

  // An invalid operation shows a zero result and a clear zero flag.
  `RV_ASSERT_IMPL(a_invalid_zero, out_valid && out_data.invalid_op, out_data.result == 32'd0 && !out_data.zero_flag, "invalid operation with non-zero result or flag")

  // A set zero flag goes with a result of zero, or of one for a comparison.
  `RV_ASSERT_IMPL(a_zero_flag, out_valid && out_data.zero_flag, out_data.result == 32'd0 || out_data.result == 32'd1, "zero flag with unexpected result")

endmodule

bind rv32im_alu_unit rv32ia_checker u_checker (.*);

// ===== tb/tb_rv32im_alu_unit.sv =====
// Self-checking testbench for the rv32im ALU unit: random and directed operations
// through valid/ready channels, results checked against an in-bench prediction.
// Depends on rv32ia_pkg and rv32im_alu_unit.
module tb_rv32im_alu_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 34;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  rv32ia_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rv32ia_pkg::out_t out_data;

  rv32ia_pkg::in_t  pending_ops[$];
  rv32ia_pkg::out_t expected_results[$];
  int   error_count = 0;
  int   send_idle_pct = 20;
  int   recv_idle_pct = 59;
  int   quiet_cycles = 0;

  rv32im_alu_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always #6 clk = ~clk;

  function automatic rv32ia_pkg::out_t alu_predict(rv32ia_pkg::in_t op);
    rv32ia_pkg::out_t r;
    logic [31:0] a, b, q, rm, ua, ub;
    logic [63:0] p;
    logic [4:0] sh;
    bit cmp;
    a = op.operand_a;
    b = op.operand_b;
    sh = b[4:0];
    cmp = 1'b0;
    r = '0;
    case (op.req_type)
      rv32ia_pkg::OP_AND:   r.result = a & b;
      rv32ia_pkg::OP_OR:    r.result = a | b;
      rv32ia_pkg::OP_ADD:   r.result = a + b;
      rv32ia_pkg::OP_XOR:   r.result = a ^ b;
      rv32ia_pkg::OP_SLT: begin
        r.result = {31'd0, $signed(a) < $signed(b)};
        cmp = 1'b1;
      end
      rv32ia_pkg::OP_SLTU: begin
        r.result = {31'd0, a < b};
        cmp = 1'b1;
      end
      rv32ia_pkg::OP_SUB:   r.result = a - b;
      rv32ia_pkg::OP_MUL: begin
        p = {32'd0, a} * {32'd0, b};
        r.result = p[31:0];
      end
      rv32ia_pkg::OP_MULH: begin
        p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        r.result = p[63:32];
      end
      rv32ia_pkg::OP_MULHU: begin
        p = {32'd0, a} * {32'd0, b};
        r.result = p[63:32];
      end
      rv32ia_pkg::OP_SLL:   r.result = a << sh;
      rv32ia_pkg::OP_SRL:   r.result = a >> sh;
      rv32ia_pkg::OP_SRA:   r.result = $signed(a) >>> sh;
      rv32ia_pkg::OP_DIV, rv32ia_pkg::OP_REM: begin
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        if (b == 0) begin
          q = '1;
          rm = a;
        end else begin
          q = ua / ub;
          rm = ua % ub;
          if (a[31] != b[31]) q = -q;
          if (a[31]) rm = -rm;
        end
        r.result = (op.req_type == rv32ia_pkg::OP_DIV) ? q : rm;
      end
      rv32ia_pkg::OP_DIVU:  r.result = (b == 0) ? '1 : a / b;
      rv32ia_pkg::OP_REMU:  r.result = (b == 0) ? a : a % b;
      default:  r.invalid_op = 1'b1;
    endcase
    if (r.invalid_op) r.zero_flag = 1'b0;
    else if (cmp) r.zero_flag = r.result[0];
    else r.zero_flag = (r.result == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("error at %0t: %s got %h want %h", $time, what, got, want);
    error_count++;
  endtask

  // Driver: valid is only lowered after a transaction, never while an item waits.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (in_valid) begin
          expected_results.insert(expected_results.size(), alu_predict(in_data));
          void'(pending_ops.pop_front());
        end
        if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_ops[0];
        end else in_valid <= 1'b0;
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_data.result, 32'd0);
        end else begin
          rv32ia_pkg::out_t want;
          want = expected_results.pop_front();
          if (out_data.result !== want.result)
            report_mismatch("result", out_data.result, want.result);
          if (out_data.zero_flag !== want.zero_flag)
            report_mismatch("zero_flag", {31'd0, out_data.zero_flag},
                            {31'd0, want.zero_flag});
          if (out_data.invalid_op !== want.invalid_op)
            report_mismatch("invalid_op", {31'd0, out_data.invalid_op},
                            {31'd0, want.invalid_op});
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("rv32im_alu_unit: mismatch");
        $finish;
      end
    end
  end

  function automatic logic [31:0] edge_word();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'h1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5: return $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [4:0] random_code();
    logic [4:0] codes[17] = '{rv32ia_pkg::OP_AND, rv32ia_pkg::OP_OR, rv32ia_pkg::OP_ADD,
      rv32ia_pkg::OP_XOR, rv32ia_pkg::OP_SLT, rv32ia_pkg::OP_SLTU, rv32ia_pkg::OP_SUB,
      rv32ia_pkg::OP_MUL, rv32ia_pkg::OP_MULH, rv32ia_pkg::OP_MULHU, rv32ia_pkg::OP_SLL,
      rv32ia_pkg::OP_SRL, rv32ia_pkg::OP_SRA, rv32ia_pkg::OP_DIV, rv32ia_pkg::OP_DIVU,
      rv32ia_pkg::OP_REM, rv32ia_pkg::OP_REMU};
    if ($urandom_range(9) == 0) return 5'($urandom_range(31));
    return codes[$urandom_range(16)];
  endfunction

  task automatic queue_op(logic [31:0] a, logic [31:0] b, logic [4:0] code);
    rv32ia_pkg::in_t t;
    t.operand_a = a;
    t.operand_b = b;
    t.req_type = code;
    pending_ops.insert(pending_ops.size(), t);
  endtask

  initial begin
    int n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: extremes, division by zero, signed overflow, high multiplies, shifts.
    queue_op(32'hFFFF_FFFF, 32'h0, rv32ia_pkg::OP_AND);
    queue_op(32'h0, 32'hFFFF_FFFF, rv32ia_pkg::OP_OR);
    queue_op(32'hFFFF_FFFF, 32'h1, rv32ia_pkg::OP_ADD);
    queue_op(32'hAAAA_AAAA, 32'h5555_5555, rv32ia_pkg::OP_XOR);
    queue_op(32'h8000_0000, 32'h7FFF_FFFF, rv32ia_pkg::OP_SLT);
    queue_op(32'h7FFF_FFFF, 32'h8000_0000, rv32ia_pkg::OP_SLT);
    queue_op(32'h1, 32'hFFFF_FFFF, rv32ia_pkg::OP_SLTU);
    queue_op(32'h0, 32'h1, rv32ia_pkg::OP_SUB);
    queue_op(32'hFFFF_FFFF, 32'hFFFF_FFFF, rv32ia_pkg::OP_MUL);
    queue_op(32'h8000_0000, 32'h8000_0000, rv32ia_pkg::OP_MULH);
    queue_op(32'hFFFF_FFFF, 32'h2, rv32ia_pkg::OP_MULH);
    queue_op(32'hFFFF_FFFF, 32'hFFFF_FFFF, rv32ia_pkg::OP_MULHU);
    queue_op(32'h1, 32'hFFFF_FFFF, rv32ia_pkg::OP_SLL);
    queue_op(32'h8000_0000, 32'h21, rv32ia_pkg::OP_SRL);
    queue_op(32'h8000_0000, 32'h1F, rv32ia_pkg::OP_SRA);
    queue_op(32'h1234_5678, 32'h0, rv32ia_pkg::OP_DIV);
    queue_op(32'h1234_5678, 32'h0, rv32ia_pkg::OP_DIVU);
    queue_op(32'h1234_5678, 32'h0, rv32ia_pkg::OP_REM);
    queue_op(32'h1234_5678, 32'h0, rv32ia_pkg::OP_REMU);
    queue_op(32'h8000_0000, 32'hFFFF_FFFF, rv32ia_pkg::OP_DIV);
    queue_op(32'h8000_0000, 32'hFFFF_FFFF, rv32ia_pkg::OP_REM);
    queue_op(32'hFFFF_FFF9, 32'h2, rv32ia_pkg::OP_REM);
    // Two codes outside the operation set.
    queue_op(32'h0, 32'h0, 5'd7);
    queue_op(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 59;
        recv_idle_pct = 20;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      n = (phase == 0) ? 560 : 580;
      repeat (n) queue_op(edge_word(), edge_word(), random_code());
      while (pending_ops.size() > 0 || in_valid) @(posedge clk);
    end
    while (expected_results.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0) $display("rv32im_alu_unit: match");
    else $display("rv32im_alu_unit: mismatch");
    $finish;
  end
endmodule
